// ===== rtl/lrod_pkg.sv =====
// shared types and constants for the light rise occupancy detector
package lrod_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned EPS_W = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_EPSILON = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MEAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TERM_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TERM_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_THRESHOLD = 3'd4;

  localparam logic [LEVEL_W-1:0] UNSET_MARK = 8'hff;
  localparam logic [LEVEL_W-1:0] STEADY_SAT = 8'd255;
  localparam logic [LEVEL_W-1:0] STEADY_FOR_ARTIFICIAL = 8'd30;
  localparam logic [LEVEL_W-1:0] STEADY_BEFORE_ON = 8'd3;
  localparam logic [LEVEL_W-1:0] STEADY_WITH_ON = 8'd3;

  typedef enum logic [1:0] {
    OCC_VACANT = 2'd0,
    OCC_HINT = 2'd1,
    OCC_LIKELY = 2'd2
  } occ_t;

  typedef struct packed {
    logic [EPS_W-1:0]   noise_epsilon;
    logic [LEVEL_W-1:0] slot_mean;
    logic [LEVEL_W-1:0] long_term_min;
    logic [LEVEL_W-1:0] long_term_max;
    logic [LEVEL_W-1:0] base_threshold;
  } cfg_t;

endpackage

// ===== rtl/light_rise_occupancy_detector_top.sv =====
// top level of the light rise occupancy detector
// Takes one light level word per cycle while in_stall is low and returns one
// occupancy word for each. A word accepted at one clock edge is classified in
// the input register, where the state update also happens; its result is then
// registered in the result register, held there until the receiver takes it.
// With the output not stalled a result can be taken every cycle, and a new word
// is taken in as the last one leaves the input register, as previous level,
// steady count and pending flag are updated at that same edge. Configuration
// writes are always ready and take effect on the next cycle; write them only
// while no sample is in flight. Writes to indexes above 4 are ignored.
module light_rise_occupancy_detector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrod_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lrod_pkg::LEVEL_W-1:0]    light_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      occupancy
);
  import lrod_pkg::*;

  cfg_t cfg;
  logic res_valid;
  logic res_stall;
  occ_t res_occ;

  lrod_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrod_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .light_level (light_level),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_occ     (res_occ)
  );

  lrod_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_occ   (res_occ),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .occupancy (occupancy)
  );

endmodule

// ===== rtl/lrod_cfg_regs.sv =====
// configuration register file
module lrod_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrod_pkg::CFG_DATA_W-1:0] cfg_data,
  output lrod_pkg::cfg_t                 cfg
);
  import lrod_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_epsilon <= 7'd4;
      cfg.slot_mean <= 8'd255;
      cfg.long_term_min <= 8'd255;
      cfg.long_term_max <= 8'd255;
      cfg.base_threshold <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NOISE_EPSILON: cfg.noise_epsilon <= cfg_data[EPS_W-1:0];
        CFG_SLOT_MEAN: cfg.slot_mean <= cfg_data;
        CFG_LONG_TERM_MIN: cfg.long_term_min <= cfg_data;
        CFG_LONG_TERM_MAX: cfg.long_term_max <= cfg_data;
        CFG_DEFAULT_THRESHOLD: cfg.base_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lrod_core.sv =====
// input register, detector state and the per-sample classification
module lrod_core (
  input  logic                         clk,
  input  logic                         rst,
  input  lrod_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrod_pkg::LEVEL_W-1:0] light_level,
  output logic                         res_valid,
  input  logic                         res_stall,
  output lrod_pkg::occ_t               res_occ
);
  import lrod_pkg::*;

  logic               s1_valid;
  logic [LEVEL_W-1:0] s1_level;
  logic               advance;

  logic [LEVEL_W-1:0] previous_level;
  logic [LEVEL_W-1:0] steady_count;
  logic               probable_waiting;
  logic [LEVEL_W-1:0] steady_count_next;
  logic               probable_waiting_next;

  logic [LEVEL_W-1:0] eps;
  logic [LEVEL_W-1:0] lo;
  logic [LEVEL_W-1:0] hi;
  logic [LEVEL_W-1:0] rise;
  logic [LEVEL_W-1:0] fall;
  logic               steady;
  logic               usable;
  logic [LEVEL_W-1:0] min_rise;
  logic [LEVEL_W-1:0] range_w;
  logic [LEVEL_W-1:0] margin_w;
  logic [LEVEL_W-1:0] margin;
  logic [LEVEL_W-1:0] thr_l;
  logic [LEVEL_W-1:0] thr_h;
  logic [LEVEL_W-1:0] below;
  logic [LEVEL_W-1:0] above;
  logic [LEVEL_W-1:0] max_dist;
  logic [LEVEL_W-1:0] mean_gap;

  assign advance = s1_valid && !res_stall;
  assign in_stall = s1_valid && res_stall;
  assign res_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level <= light_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= '0;
      steady_count <= '0;
      probable_waiting <= 1'b0;
    end else if (advance) begin
      previous_level <= s1_level;
      steady_count <= steady_count_next;
      probable_waiting <= probable_waiting_next;
    end
  end

  always_comb begin
    eps = {1'b0, cfg.noise_epsilon};
    lo = (cfg.long_term_min == UNSET_MARK) ? eps : cfg.long_term_min;
    hi = (cfg.long_term_max == UNSET_MARK) ? UNSET_MARK - eps : cfg.long_term_max;
    rise = s1_level - previous_level;
    fall = previous_level - s1_level;
    steady = rise < eps;
    usable = (cfg.slot_mean != UNSET_MARK) && (cfg.slot_mean > lo);
    min_rise = usable ? ((cfg.slot_mean - lo) >> 1) : (cfg.base_threshold >> 1);
    range_w = hi - lo;
    margin_w = range_w >> 1;
    margin = margin_w >> 2;
    thr_l = lo + margin;
    thr_h = hi - margin_w;
    below = cfg.slot_mean - lo;
    above = hi - cfg.slot_mean;
    max_dist = ((below < above) ? below : above) >> 1;
    mean_gap = (s1_level > cfg.slot_mean) ? s1_level - cfg.slot_mean
                                          : cfg.slot_mean - s1_level;

    res_occ = OCC_VACANT;
    steady_count_next = steady_count;
    probable_waiting_next = probable_waiting;

    if (s1_level < previous_level) begin
      if (fall >= eps) begin
        steady_count_next = '0;
        probable_waiting_next = 1'b0;
      end else if (steady_count < STEADY_SAT) begin
        steady_count_next = steady_count + 8'd1;
      end
    end else begin
      if (!steady) begin
        steady_count_next = '0;
      end else if (steady_count < STEADY_SAT) begin
        steady_count_next = steady_count + 8'd1;
      end

      if (probable_waiting) begin
        if (steady_count_next >= STEADY_WITH_ON) begin
          res_occ = OCC_LIKELY;
          probable_waiting_next = 1'b0;
        end
      end else if (!steady && steady_count >= STEADY_BEFORE_ON) begin
        if (rise >= min_rise) begin
          if (previous_level > lo || steady_count < STEADY_SAT) begin
            res_occ = OCC_LIKELY;
            probable_waiting_next = 1'b0;
          end else begin
            res_occ = OCC_HINT;
            probable_waiting_next = 1'b1;
          end
        end
      end else if (steady_count_next >= STEADY_FOR_ARTIFICIAL && lo < cfg.slot_mean
                   && cfg.slot_mean < hi) begin
        if (range_w > {cfg.noise_epsilon, 1'b0}) begin
          if (s1_level > thr_l && s1_level < thr_h && mean_gap <= max_dist) begin
            res_occ = OCC_HINT;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/lrod_out_reg.sv =====
// result register between the core and the output channel
module lrod_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_stall,
  input  lrod_pkg::occ_t res_occ,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     occupancy
);
  import lrod_pkg::*;

  assign res_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!res_stall) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_stall && res_valid) begin
      occupancy <= res_occ;
    end
  end

endmodule

// ===== rtl/lrod_checker.sv =====
// port-level assertions for the detector top level and their bind
module lrod_port_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] occupancy
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(occupancy))
    else $error("result word changed while stalled");

  a_occ_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy != 2'd3)
    else $error("occupancy code out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind light_rise_occupancy_detector_top lrod_port_props u_lrod_port_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .occupancy (occupancy)
);

// ===== test/lrod_checker.sv =====
// checker: predicts occupancy words from observed traffic and compares them
`timescale 1ns / 100ps
module lrod_checker
  import lrod_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [LEVEL_W-1:0]    light_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            occupancy,
  output int                    error_count,
  output int                    pending
);

  logic [EPS_W-1:0]   eps_reg;
  logic [LEVEL_W-1:0] mean_reg;
  logic [LEVEL_W-1:0] min_reg;
  logic [LEVEL_W-1:0] max_reg;
  logic [LEVEL_W-1:0] thr_reg;

  logic [LEVEL_W-1:0] last_level;
  logic [LEVEL_W-1:0] steady_ticks;
  logic               probable_held;

  occ_t expected_occ[$];

  function automatic occ_t classify_level(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] eps, lo, hi, rise, drop, old_ticks, min_rise;
    logic [LEVEL_W-1:0] span, margin_w, margin, thr_l, thr_h;
    logic [LEVEL_W-1:0] below, above, max_gap, gap_to_mean;
    logic               steady, usable;
    occ_t               occ;
    eps = {1'b0, eps_reg};
    occ = OCC_VACANT;
    if (lvl < last_level) begin
      drop = last_level - lvl;
      if (drop >= eps) begin
        steady_ticks = '0;
        probable_held = 1'b0;
      end else if (steady_ticks < STEADY_SAT) begin
        steady_ticks = steady_ticks + 8'd1;
      end
      last_level = lvl;
      return OCC_VACANT;
    end
    lo = (min_reg == UNSET_MARK) ? eps : min_reg;
    hi = (max_reg == UNSET_MARK) ? UNSET_MARK - eps : max_reg;
    rise = lvl - last_level;
    steady = rise < eps;
    old_ticks = steady_ticks;
    if (!steady) begin
      steady_ticks = '0;
    end else if (steady_ticks < STEADY_SAT) begin
      steady_ticks = steady_ticks + 8'd1;
    end
    if (probable_held) begin
      if (steady_ticks >= STEADY_WITH_ON) begin
        occ = OCC_LIKELY;
        probable_held = 1'b0;
      end
    end else if (!steady && old_ticks >= STEADY_BEFORE_ON) begin
      usable = (mean_reg != UNSET_MARK) && (mean_reg > lo);
      if (usable) begin
        min_rise = mean_reg - lo;
        min_rise = min_rise >> 1;
      end else begin
        min_rise = thr_reg >> 1;
      end
      if (rise >= min_rise) begin
        if (last_level > lo || old_ticks < STEADY_SAT) begin
          occ = OCC_LIKELY;
          probable_held = 1'b0;
        end else begin
          occ = OCC_HINT;
          probable_held = 1'b1;
        end
      end
    end else if (steady_ticks >= STEADY_FOR_ARTIFICIAL && lo < mean_reg && mean_reg < hi) begin
      span = hi - lo;
      if ({1'b0, span} > {eps, 1'b0}) begin
        margin_w = span >> 1;
        margin = margin_w >> 2;
        thr_l = lo + margin;
        thr_h = hi - margin_w;
        below = mean_reg - lo;
        above = hi - mean_reg;
        max_gap = ((below < above) ? below : above) >> 1;
        gap_to_mean = (lvl > mean_reg) ? lvl - mean_reg : mean_reg - lvl;
        if (lvl > thr_l && lvl < thr_h && gap_to_mean <= max_gap) begin
          occ = OCC_HINT;
        end
      end
    end
    last_level = lvl;
    return occ;
  endfunction

  always @(posedge clk) begin
    occ_t want;
    if (rst) begin
      eps_reg = 7'd4;
      mean_reg = 8'd255;
      min_reg = 8'd255;
      max_reg = 8'd255;
      thr_reg = 8'd16;
      last_level = '0;
      steady_ticks = '0;
      probable_held = 1'b0;
      expected_occ.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NOISE_EPSILON:     eps_reg = cfg_data[EPS_W-1:0];
          CFG_SLOT_MEAN:         mean_reg = cfg_data;
          CFG_LONG_TERM_MIN:     min_reg = cfg_data;
          CFG_LONG_TERM_MAX:     max_reg = cfg_data;
          CFG_DEFAULT_THRESHOLD: thr_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_occ.push_back(classify_level(light_level));
      end
      if (out_valid && !out_stall) begin
        if (expected_occ.size() == 0) begin
          $error("occupancy word with none expected: actual %0d", occupancy);
          error_count++;
        end else begin
          want = expected_occ.pop_front();
          if (occupancy !== want) begin
            $error("occupancy mismatch: expected %0d actual %0d", want, occupancy);
            error_count++;
          end
        end
      end
    end
    pending = expected_occ.size();
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top: light level stimulus, config phases and final verdict
`timescale 1ns / 100ps
module tb_top;
  import lrod_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    light_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            occupancy;

  int error_count;
  int pending;
  int sent_count;
  int cycle_count;

  int sh_eps;
  int sh_mean;
  int sh_min;
  int sh_max;
  int sh_thr;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  light_rise_occupancy_detector_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .light_level (light_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .occupancy   (occupancy)
  );

  lrod_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .light_level (light_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .occupancy   (occupancy),
    .error_count (error_count),
    .pending     (pending)
  );

  function automatic bit in_calm_window();
    return sent_count >= 400 && sent_count < 650;
  endfunction

  task automatic push_level(input int v);
    if (!in_calm_window() && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    light_level <= v[LEVEL_W-1:0];
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NOISE_EPSILON:     sh_eps = data & 127;
      CFG_SLOT_MEAN:         sh_mean = data & 255;
      CFG_LONG_TERM_MIN:     sh_min = data & 255;
      CFG_LONG_TERM_MAX:     sh_max = data & 255;
      CFG_DEFAULT_THRESHOLD: sh_thr = data & 255;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int phase);
    case (phase)
      1: begin
        // zero noise floor via masked data bit
        write_reg(CFG_NOISE_EPSILON, 8'h80);
        write_reg(CFG_SLOT_MEAN, 0);
        write_reg(CFG_LONG_TERM_MIN, 0);
        write_reg(CFG_LONG_TERM_MAX, 255);
      end
      2: begin
        // disordered bounds, widest noise floor
        write_reg(CFG_NOISE_EPSILON, 8'hff);
        write_reg(CFG_SLOT_MEAN, 255);
        write_reg(CFG_LONG_TERM_MIN, 255);
        write_reg(CFG_LONG_TERM_MAX, 0);
        write_reg(CFG_DEFAULT_THRESHOLD, 255);
      end
      3: begin
        write_reg(CFG_NOISE_EPSILON, 4);
        write_reg(CFG_SLOT_MEAN, 120);
        write_reg(CFG_LONG_TERM_MIN, 20);
        write_reg(CFG_LONG_TERM_MAX, 220);
        write_reg(CFG_DEFAULT_THRESHOLD, 40);
        write_reg(CFG_SPARE_LO, $urandom_range(0, 255));
      end
      4: begin
        write_reg(CFG_DEFAULT_THRESHOLD, 0);
        write_reg(CFG_NOISE_EPSILON, 3);
        write_reg(CFG_SLOT_MEAN, 255);
        write_reg(CFG_LONG_TERM_MIN, 255);
        write_reg(CFG_LONG_TERM_MAX, 255);
      end
      default: begin
        write_reg(CFG_NOISE_EPSILON, $urandom_range(1, 10));
        write_reg(CFG_SLOT_MEAN, $urandom_range(0, 254));
        write_reg(CFG_LONG_TERM_MIN, ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 90));
        write_reg(CFG_LONG_TERM_MAX,
                  ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(140, 254));
        write_reg(CFG_DEFAULT_THRESHOLD, $urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_HI, $urandom_range(0, 255));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // alternates base and base plus a jitter below the noise floor
  task automatic steady_run(input int base, input int n);
    int j;
    int k;
    for (k = 0; k < n; k++) begin
      j = (sh_eps > 0) ? $urandom_range(0, sh_eps - 1) : 0;
      if (base + j > 254) j = 0;
      push_level((k % 2 == 1) ? base + j : base);
    end
  endtask

  task automatic run_sequence();
    int kind;
    int base;
    int peak;
    int lo;
    int n;
    int k;
    kind = $urandom_range(0, 99);
    lo = (sh_min == 255) ? sh_eps : sh_min;
    if (kind < 2) begin
      // dark and steady long enough to saturate, then a rise
      base = $urandom_range(0, (lo > 254) ? 254 : lo);
      for (k = 0; k < 258; k++) push_level(base);
      peak = base + sh_eps + $urandom_range(0, 60);
      if (peak > 254) peak = 254;
      push_level(peak);
      steady_run(peak, $urandom_range(2, 5));
      if ($urandom_range(0, 1) == 1) push_level($urandom_range(0, peak));
    end else if (kind < 45) begin
      base = $urandom_range(0, 254);
      steady_run(base, $urandom_range(2, 8));
      peak = $urandom_range(base, 254);
      push_level(peak);
      steady_run(peak, $urandom_range(0, 3));
    end else if (kind < 75) begin
      // long steady light close to the slot mean
      base = (sh_mean == 255) ? $urandom_range(0, 254) : sh_mean + $urandom_range(0, 6) - 3;
      if (base < 0) base = 0;
      if (base > 254) base = 254;
      steady_run(base, $urandom_range(26, 40));
    end else if (kind < 90) begin
      peak = $urandom_range(0, 254);
      push_level(peak);
      push_level($urandom_range(0, peak));
    end else begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) push_level($urandom_range(0, 254));
    end
  endtask

  task automatic directed_levels();
    int seq[20];
    int k;
    seq = '{0, 0, 0, 0, 200, 202, 201, 203, 254, 255,
            255, 255, 255, 0, 2, 1, 3, 2, 9, 128};
    for (k = 0; k < 20; k++) push_level(seq[k]);
  endtask

  initial begin
    int phase;
    int phase_start;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    light_level = '0;
    sent_count = 0;
    sh_eps = 4;
    sh_mean = 255;
    sh_min = 255;
    sh_max = 255;
    sh_thr = 16;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        directed_levels();
      end else begin
        drain();
        set_phase(phase);
      end
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_WORDS) run_sequence();
    end
    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the pipe, calm window
  initial begin
    int hold_left;
    bit held_once;
    out_stall = 1'b0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && sent_count >= 150) begin
        held_once = 1'b1;
        hold_left = 120;
      end
      if (hold_left == 0 && $urandom_range(0, 999) == 0) hold_left = $urandom_range(40, 100);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (in_calm_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 19);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
